FILE: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: screen geometry,
// control codes, request codes and the sequencer state type.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 4;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CELL_W     = 16;

  // Character codes
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] TAB_CODE     = 8'd9;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] BLANK_ATTR   = 8'h0F;
  localparam logic [7:0] BRUSH_RESET  = 8'h0F;
  localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_CHAR, BLANK_ATTR};

  // Request codes
  typedef enum logic [1:0] {
    REQ_PRINT = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_INIT,    // clearing pass after reset
    S_IDLE,    // ready for a transaction
    S_READ,    // cell read data returning
    S_SCROLL,  // copy each row up by one
    S_DRAIN,   // write the last copied cell
    S_BLANK,   // blank the bottom row
    S_PUT,     // write the character held over a scroll
    S_CLEAR    // blank every cell
  } state_t;

endpackage

FILE: rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text console: a screen of character/attribute cells and a cursor, with
// print, clear and cell read requests driven by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one request per transaction:
//   print a byte, clear the screen or read one cell. Every request returns
//   one transaction on out_valid/out_ready with the cell (reads only) and
//   the cursor after the request. cfg_wr_en/cfg_wr_data set the brush
//   attribute used by printed characters; write it only while idle.
// Request flow:
//   Print (plain, tab, newline without scroll) and unused requests: result
//   in the cycle after acceptance. Read: cell store read, then result.
//   Newline on the bottom row scrolls: the cell store is walked through its
//   single read and write ports, then the bottom row is blanked; a print that
//   wraps from the bottom row then writes its held character. Clear blanks
//   every cell. One request is in flight at a time; in_ready is low while it works.
// Reset:
//   rst_n runs a clearing pass that blanks the cell store; in_ready
//   stays low until it ends. Cursor goes home, brush
//   returns to 0x0F.
// Stall:
//   The result register holds until taken; a new request is accepted in the
//   cycle the pending result drains.
// ----------------------------------------------------------------------------
module text_console_writer_top (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_char_code,
  input  logic [4:0] in_read_row,
  input  logic [6:0] in_read_col,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_cell_char,
  output logic [7:0] out_cell_attr,
  output logic [4:0] out_cursor_row,
  output logic [7:0] out_cursor_col,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  import tcw_pkg::*;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   cp_dst_r, cp_dst_nxt;
  logic                cp_vld_r, cp_vld_nxt;
  logic                put_pend_r, put_pend_nxt;
  logic [7:0]          put_char_r, put_char_nxt;
  logic                rd_hit_r, rd_hit_nxt;
  logic [4:0]          cur_row_r, cur_row_nxt;
  logic [7:0]          cur_col_r, cur_col_nxt;
  logic [ADDR_W-1:0]   row_base_r, row_base_nxt;
  logic [7:0]          brush_r;

  logic                out_valid_r;
  logic [7:0]          out_char_r, out_attr_r;
  logic [4:0]          out_row_r;
  logic [7:0]          out_col_r;
  logic                load;
  logic [CELL_W-1:0]   cell_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [CELL_W-1:0]   ram_wdata, ram_rdata;

  logic                accept;
  logic                is_nl, is_tab, last_row, past_end, cnt_last;
  logic [8:0]          tab_sum;
  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_hit;

  // Request decode
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_nl    = (in_char_code == NEWLINE_CODE);
  assign is_tab   = (in_char_code == TAB_CODE);
  assign last_row = (cur_row_r == 5'(ROWS - 1));
  assign past_end = (cur_col_r >= 8'(COLUMNS));
  assign cnt_last = (cnt_r == ADDR_W'(CELL_COUNT - 1));
  assign tab_sum  = {1'b0, cur_col_r} + 9'(TAB_WIDTH);
  assign rd_hit   = (int'(in_read_row) < ROWS) && (int'(in_read_col) < COLUMNS);
  assign rd_addr  = ADDR_W'(ADDR_W'(in_read_row) * ADDR_W'(COLUMNS))
                  + ADDR_W'(in_read_col);

  // Cell store
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT, S_CLEAR: begin
        if (cnt_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (req_t'(in_req_type))
            REQ_PRINT: begin
              if (!is_tab && (is_nl || past_end) && last_row) state_nxt = S_SCROLL;
            end
            REQ_CLEAR: state_nxt = S_CLEAR;
            REQ_READ:  state_nxt = S_READ;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_READ:   state_nxt = S_IDLE;
      S_SCROLL: begin
        if (cnt_last) state_nxt = S_DRAIN;
      end
      S_DRAIN:  state_nxt = S_BLANK;
      S_BLANK: begin
        if (cnt_last) state_nxt = put_pend_r ? S_PUT : S_IDLE;
      end
      S_PUT:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath and store control per state
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = cnt_r;
    ram_wdata    = BLANK_CELL;
    ram_raddr    = cnt_r;
    load         = 1'b0;
    cell_nxt     = '0;
    cnt_nxt      = cnt_r;
    cp_dst_nxt   = cp_dst_r;
    cp_vld_nxt   = 1'b0;
    put_pend_nxt = put_pend_r;
    put_char_nxt = put_char_r;
    rd_hit_nxt   = rd_hit_r;
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    row_base_nxt = row_base_r;
    case (state_r)
      S_INIT, S_CLEAR: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_last ? '0 : cnt_r + 1'b1;
        load    = cnt_last && (state_r == S_CLEAR);
      end
      S_IDLE: begin
        if (accept) begin
          case (req_t'(in_req_type))
            REQ_PRINT: begin
              if (is_tab) begin
                cur_col_nxt = tab_sum[8] ? 8'hFF : tab_sum[7:0];
                load        = 1'b1;
              end else if (is_nl || past_end) begin
                if (last_row) begin
                  // scroll first; a printable byte waits until after it
                  cur_col_nxt  = '0;
                  cnt_nxt      = ADDR_W'(COLUMNS);
                  put_pend_nxt = !is_nl;
                  put_char_nxt = in_char_code;
                end else if (is_nl) begin
                  cur_col_nxt  = '0;
                  cur_row_nxt  = cur_row_r + 1'b1;
                  row_base_nxt = row_base_r + ADDR_W'(COLUMNS);
                  load         = 1'b1;
                end else begin
                  ram_we       = 1'b1;
                  ram_waddr    = row_base_r + ADDR_W'(COLUMNS);
                  ram_wdata    = {in_char_code, brush_r};
                  cur_col_nxt  = 8'd1;
                  cur_row_nxt  = cur_row_r + 1'b1;
                  row_base_nxt = row_base_r + ADDR_W'(COLUMNS);
                  load         = 1'b1;
                end
              end else begin
                ram_we      = 1'b1;
                ram_waddr   = row_base_r + ADDR_W'(cur_col_r);
                ram_wdata   = {in_char_code, brush_r};
                cur_col_nxt = cur_col_r + 1'b1;
                load        = 1'b1;
              end
            end
            REQ_CLEAR: begin
              cur_row_nxt  = '0;
              cur_col_nxt  = '0;
              row_base_nxt = '0;
              cnt_nxt      = '0;
            end
            REQ_READ: begin
              ram_raddr  = rd_addr;
              rd_hit_nxt = rd_hit;
            end
            default: load = 1'b1;
          endcase
        end
      end
      S_READ: begin
        load     = 1'b1;
        cell_nxt = rd_hit_r ? ram_rdata : '0;
      end
      S_SCROLL: begin
        // read source cell now, write it one row up next cycle
        ram_we     = cp_vld_r;
        ram_waddr  = cp_dst_r;
        ram_wdata  = ram_rdata;
        cp_vld_nxt = 1'b1;
        cp_dst_nxt = cnt_r - ADDR_W'(COLUMNS);
        cnt_nxt    = cnt_last ? ADDR_W'((ROWS - 1) * COLUMNS) : cnt_r + 1'b1;
      end
      S_DRAIN: begin
        ram_we    = cp_vld_r;
        ram_waddr = cp_dst_r;
        ram_wdata = ram_rdata;
      end
      S_BLANK: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_last ? '0 : cnt_r + 1'b1;
        load    = cnt_last && !put_pend_r;
      end
      S_PUT: begin
        ram_we       = 1'b1;
        ram_waddr    = row_base_r;
        ram_wdata    = {put_char_r, brush_r};
        cur_col_nxt  = 8'd1;
        put_pend_nxt = 1'b0;
        load         = 1'b1;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // Control and cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      cp_vld_r    <= 1'b0;
      put_pend_r  <= 1'b0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      row_base_r  <= '0;
      brush_r     <= BRUSH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cp_vld_r    <= cp_vld_nxt;
      put_pend_r  <= put_pend_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      row_base_r  <= row_base_nxt;
      if (cfg_wr_en) brush_r <= cfg_wr_data;
      out_valid_r <= load || (out_valid_r && !out_ready);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cp_dst_r   <= cp_dst_nxt;
    put_char_r <= put_char_nxt;
    rd_hit_r   <= rd_hit_nxt;
    if (load) begin
      out_char_r <= cell_nxt[15:8];
      out_attr_r <= cell_nxt[7:0];
      out_row_r  <= cur_row_nxt;
      out_col_r  <= cur_col_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_attr  = out_attr_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;

  // Checks
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cur_row_r) < ROWS)
    else $error("cursor row out of range");

  a_row_base: assert property (@(posedge clk) disable iff (!rst_n)
    int'(row_base_r) == int'(cur_row_r) * COLUMNS)
    else $error("row base out of step with cursor row");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while pending");

  a_put_after_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |-> (cur_col_r == '0 && last_row))
    else $error("held character written off the bottom row start");

endmodule

FILE: sim/tb_text_console_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_top
// Self-checking bench for the text console writer. A predictor in this file
// keeps its own screen, cursor and brush. Each accepted request adds one
// expected result to a queue, and each result leaving the block is compared
// with the oldest entry. The stimulus covers directed corner requests, tab
// saturation, scrolling text and a random mix under several brush settings,
// with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_text_console_writer_top;
  import tcw_pkg::*;

  localparam int ITEM_TARGET = 1300;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [4:0] cursor_row;
    logic [7:0] cursor_col;
  } console_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_req_type = REQ_NONE;
  logic [7:0] in_char_code = '0;
  logic [4:0] in_read_row = '0;
  logic [6:0] in_read_col = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_cell_char;
  logic [7:0] out_cell_attr;
  logic [4:0] out_cursor_row;
  logic [7:0] out_cursor_col;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  // Predicted console state
  logic [7:0] scr_char [CELL_COUNT];
  logic [7:0] scr_attr [CELL_COUNT];
  logic [4:0] cur_row;
  logic [7:0] cur_col;
  logic [7:0] brush_attr;

  console_result_t expected_results[$];

  int errors;
  int items_sent;
  int reads_done;
  int reads_out_of_range;
  int scrolls;
  int wraps;
  int clears;
  int tab_saturations;
  int brush_writes;
  int burst_left;
  int idle_cycles;
  logic [7:0] ready_pattern = 8'hFF;
  int pattern_age;

  text_console_writer_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_char_code   (in_char_code),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Blank every cell and home the cursor
  function automatic void screen_blank_all();
    int i;
    for (i = 0; i < CELL_COUNT; i++) begin
      scr_char[i] = BLANK_CHAR;
      scr_attr[i] = BLANK_ATTR;
    end
    cur_row = '0;
    cur_col = '0;
  endfunction

  // Move to the next row, or scroll up and blank the bottom row
  function automatic void screen_line_feed();
    int i;
    cur_col = '0;
    if (cur_row < ROWS - 1) begin
      cur_row++;
    end else begin
      for (i = COLUMNS; i < CELL_COUNT; i++) begin
        scr_char[i - COLUMNS] = scr_char[i];
        scr_attr[i - COLUMNS] = scr_attr[i];
      end
      for (i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) begin
        scr_char[i] = BLANK_CHAR;
        scr_attr[i] = BLANK_ATTR;
      end
      scrolls++;
    end
  endfunction

  function automatic void screen_print(logic [7:0] ch);
    int idx;
    int next_col;
    if (ch == NEWLINE_CODE) begin
      screen_line_feed();
    end else if (ch == TAB_CODE) begin
      // Saturate the column at 255
      next_col = int'(cur_col) + TAB_WIDTH;
      if (next_col > 255) begin
        next_col = 255;
        tab_saturations++;
      end
      cur_col = 8'(next_col);
    end else begin
      // Take a newline first when past the line end
      if (cur_col >= COLUMNS) begin
        screen_line_feed();
        wraps++;
      end
      idx = int'(cur_row) * COLUMNS + int'(cur_col);
      scr_char[idx] = ch;
      scr_attr[idx] = brush_attr;
      if (cur_col != 8'hFF) cur_col++;
    end
  endfunction

  function automatic console_result_t predict_request(req_t req, logic [7:0] ch,
                                                      logic [4:0] rr, logic [6:0] rc);
    console_result_t res;
    res = '0;
    case (req)
      REQ_PRINT: begin
        screen_print(ch);
      end
      REQ_CLEAR: begin
        screen_blank_all();
        clears++;
      end
      REQ_READ: begin
        reads_done++;
        if (rr < ROWS && rc < COLUMNS) begin
          res.cell_char = scr_char[int'(rr) * COLUMNS + int'(rc)];
          res.cell_attr = scr_attr[int'(rr) * COLUMNS + int'(rc)];
        end else begin
          reads_out_of_range++;
        end
      end
      default: ;
    endcase
    res.cursor_row = cur_row;
    res.cursor_col = cur_col;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking and watchdog
  // --------------------------------------------------------------------------

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    console_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing expected, expected none, actual %h %h %0d %0d",
                 $time, out_cell_char, out_cell_attr, out_cursor_row, out_cursor_col);
      end else begin
        want = expected_results.pop_front();
        check_field("cell_char", want.cell_char, out_cell_char);
        check_field("cell_attr", want.cell_attr, out_cell_attr);
        check_field("cursor_row", 8'(want.cursor_row), 8'(out_cursor_row));
        check_field("cursor_col", want.cursor_col, out_cursor_col);
      end
    end
    // Abort when no transaction moves for too long
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, expected_results.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Stall the result channel on a rotating pattern that changes now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      pattern_age = 0;
    end else begin
      if (pattern_age == 0) begin
        pattern_age = $urandom_range(32, 255);
        if ($urandom_range(0, 3) == 0) ready_pattern = 8'hFF;
        else ready_pattern = 8'($urandom_range(1, 255));
      end
      pattern_age--;
      ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
      out_ready <= ready_pattern[0];
    end
  end

  // --------------------------------------------------------------------------
  // Request driving
  // --------------------------------------------------------------------------

  // Send one request in bursts with random gaps; record its expected result
  task automatic send_request(req_t req, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(64, 200);
      else burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_char_code <= ch;
    in_read_row  <= rr;
    in_read_col  <= rc;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_request(req, ch, rr, rc));
    items_sent++;
  endtask

  task automatic put_char(logic [7:0] ch);
    send_request(REQ_PRINT, ch, 5'($urandom), 7'($urandom));
  endtask

  task automatic read_cell(logic [4:0] rr, logic [6:0] rc);
    send_request(REQ_READ, 8'($urandom), rr, rc);
  endtask

  // Half the reads on the cursor row, the rest on screen or in the field range
  task automatic random_read();
    case ($urandom_range(0, 9))
      0:       read_cell(5'($urandom), 7'($urandom));
      1, 2, 3,
      4, 5:    read_cell(cur_row, 7'($urandom_range(0, COLUMNS - 1)));
      default: read_cell(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
    endcase
  endtask

  function automatic logic [7:0] printable_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == NEWLINE_CODE || b == TAB_CODE) b = 8'h7E;
    return b;
  endfunction

  // Hold off until every expected result has come and the block is idle
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_brush(logic [7:0] value);
    wait_results_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    brush_attr = value;
    brush_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner requests on a freshly reset screen, with the reset brush, then 0xF0
  task automatic test_directed_requests();
    read_cell(5'd0, 7'd0);
    read_cell(5'(ROWS - 1), 7'(COLUMNS - 1));
    read_cell(5'(ROWS), 7'd0);
    read_cell(5'd0, 7'(COLUMNS));
    read_cell(5'h1F, 7'h7F);
    put_char("A");
    put_char(8'h00);
    put_char(8'hFF);
    put_char(TAB_CODE);
    put_char("#");
    read_cell(5'd0, 7'd0);
    read_cell(5'd0, 7'd2);
    read_cell(5'd0, 7'd7);
    put_char(NEWLINE_CODE);
    send_request(REQ_NONE, 8'hFF, 5'h1F, 7'h7F);
    write_brush(8'hF0);
    put_char("B");
    read_cell(5'd1, 7'd0);
    send_request(REQ_CLEAR, 8'h00, 5'h00, 7'h00);
    read_cell(5'd0, 7'd0);
    read_cell(5'd1, 7'd0);
    send_request(REQ_NONE, 8'h00, 5'h00, 7'h00);
  endtask

  // Tab the column up to its saturation point, then print to force a wrap
  task automatic test_tab_saturation();
    send_request(REQ_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
    repeat ($urandom_range(0, 3)) put_char(printable_byte());
    repeat (66) put_char(TAB_CODE);
    put_char(printable_byte());
    put_char(TAB_CODE);
    read_cell(cur_row, 7'd0);
  endtask

  // Lines of random text, some past the line end, enough to scroll
  task automatic test_scrolling_text();
    int len;
    int k;
    write_brush(8'hFF);
    send_request(REQ_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
    for (k = 0; k < 30; k++) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(COLUMNS - 4, COLUMNS + 4)
                                         : $urandom_range(0, 12);
      repeat (len) put_char(printable_byte());
      repeat ($urandom_range(0, 2)) random_read();
      put_char(NEWLINE_CODE);
    end
    // Overrun the bottom row so that the wrap itself scrolls
    repeat (COLUMNS + 3) put_char(printable_byte());
    for (k = 0; k < 6; k++) read_cell(5'(ROWS - 1 - k % 3), 7'($urandom_range(0, COLUMNS - 1)));
  endtask

  // Random requests in phases, each phase under its own brush
  task automatic test_random_mix();
    int phase;
    int phase_left;
    int sel;
    logic [7:0] next_brush;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0:       next_brush = 8'h00;
        1:       next_brush = 8'hFF;
        2:       next_brush = BRUSH_RESET;
        default: next_brush = 8'($urandom);
      endcase
      write_brush(next_brush);
      phase++;
      phase_left = $urandom_range(100, 200);
      while (phase_left > 0 && items_sent < ITEM_TARGET) begin
        sel = $urandom_range(0, 99);
        if (sel < 50) put_char(printable_byte());
        else if (sel < 58) put_char(NEWLINE_CODE);
        else if (sel < 62) put_char(TAB_CODE);
        else if (sel < 86) random_read();
        else if (sel < 87) send_request(REQ_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
        else if (sel < 89) send_request(REQ_NONE, 8'($urandom), 5'($urandom), 7'($urandom));
        else if (sel < 91) put_char(8'($urandom));
        else if (sel < 93) repeat ($urandom_range(COLUMNS - 2, COLUMNS + 4)) put_char(printable_byte());
        else if (sel < 94) wait_results_drained();
        else put_char(printable_byte());
        phase_left--;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    brush_attr = BRUSH_RESET;
    screen_blank_all();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_requests();
    test_tab_saturation();
    test_scrolling_text();
    test_random_mix();

    // Drain the remaining results and watch for strays
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Ran %0d requests: %0d reads (%0d outside the screen), %0d clears, %0d brush values.",
             items_sent, reads_done, reads_out_of_range, clears, brush_writes + 1);
    $display("Screen saw %0d scrolls, %0d line wraps and %0d tab saturations.",
             scrolls, wraps, tab_saturations);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/text_console_writer_top.sv
sim/tb_text_console_writer_top.sv
